### design/tsm_pkg.sv
// ----------------------------------------------------------------------------
// Two-way sorted merge package
// Shared widths, operation codes, command and result types for the merge unit.
// ----------------------------------------------------------------------------
package tsm_pkg;

   // Field widths of the request and result channels.
   localparam int VALUE_W = 32;
   localparam int OP_W    = 2;

   // Default number of entries held in each list buffer.
   localparam int LIST_DEPTH = 32;

   // Command queue between the front and the back end.
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

   // Operation codes carried on the request channel.
   localparam logic [OP_W-1:0] OP_APPEND_FIRST  = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND_SECOND = 2'd1;
   localparam logic [OP_W-1:0] OP_MERGE         = 2'd2;

   // Classified command kinds handed to the back end.
   typedef enum logic [1:0] {
      CMD_APPEND_FIRST,
      CMD_APPEND_SECOND,
      CMD_MERGE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [VALUE_W-1:0]  value;
   } cmd_type;

   // One merge result as it leaves the back end.
   typedef struct packed {
      logic [VALUE_W-1:0]  value;
      logic                last;
      logic                empty;
      logic                overflow;
   } rsp_type;

   // Back-end sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_PICK
   } state_type;

endpackage

### design/tsm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
module tsm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/tsm_front.sv
// ----------------------------------------------------------------------------
// Merge unit front end
// Accepts request transactions, classifies the operation code and queues the
// resulting commands for the back end. Unused codes are accepted and dropped.
// ----------------------------------------------------------------------------
module tsm_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [tsm_pkg::OP_W-1:0]     req_op,
   input  logic [tsm_pkg::VALUE_W-1:0]  req_value,
   output logic                         cmd_valid,
   output tsm_pkg::cmd_type             cmd,
   input  logic                         cmd_ready
);

   localparam int FW = tsm_pkg::CMDQ_AW + 1;

   tsm_pkg::cmd_type                  entry_ff [tsm_pkg::CMDQ_DEPTH];
   logic [tsm_pkg::CMDQ_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [tsm_pkg::CMDQ_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0]                     fill_ff, fill_in;
   tsm_pkg::cmd_kind_type             kind;
   logic                              keep;
   logic                              push_q;
   logic                              pop_q;

   // Classify the operation code; codes without meaning produce no command.
   always_comb begin
      kind = tsm_pkg::CMD_APPEND_FIRST;
      keep = 1'b1;
      case (req_op)
         tsm_pkg::OP_APPEND_FIRST:  kind = tsm_pkg::CMD_APPEND_FIRST;
         tsm_pkg::OP_APPEND_SECOND: kind = tsm_pkg::CMD_APPEND_SECOND;
         tsm_pkg::OP_MERGE:         kind = tsm_pkg::CMD_MERGE;
         default:                   keep = 1'b0;
      endcase
   end

   // Queue handshakes on both sides.
   assign req_full  = (fill_ff == FW'(tsm_pkg::CMDQ_DEPTH));
   assign cmd_valid = (fill_ff != '0);
   assign cmd       = entry_ff[rd_ptr_ff];
   assign push_q    = req_push && !req_full && keep;
   assign pop_q     = cmd_valid && cmd_ready;

   // Pointer and fill level updates.
   always_comb begin
      wr_ptr_in = push_q ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_q ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push_q && !pop_q) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop_q && !push_q) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Queue payload storage needs no reset.
   always_ff @(posedge clock) begin
      if (push_q) begin
         entry_ff[wr_ptr_ff] <= '{kind: kind, value: req_value};
      end
   end

endmodule

### design/tsm_back.sv
// ----------------------------------------------------------------------------
// Merge unit back end
// Holds both list buffers, carries out append commands and runs the stable
// two-pointer merge into an output register, fetching before each pick.
// ----------------------------------------------------------------------------
module tsm_back #(
   parameter int LIST_DEPTH = tsm_pkg::LIST_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  tsm_pkg::cmd_type  cmd,
   output logic              cmd_ready,
   output logic              rsp_valid,
   output tsm_pkg::rsp_type  rsp,
   input  logic              rsp_pop
);

   localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CW = $clog2(LIST_DEPTH + 1);

   tsm_pkg::state_type           state_ff, state_in;
   logic [CW-1:0]                first_count_ff, first_count_in;
   logic [CW-1:0]                second_count_ff, second_count_in;
   logic                         dropped_ff, dropped_in;
   logic [CW-1:0]                i_ff, i_in;
   logic [CW-1:0]                j_ff, j_in;
   logic                         out_valid_ff, out_valid_in;
   tsm_pkg::rsp_type             out_ff, out_in;

   logic                         do_cmd;
   logic                         first_full, second_full;
   logic                         wr_first, wr_second;
   logic [tsm_pkg::VALUE_W-1:0]  first_rd, second_rd;
   logic                         a_ok, b_ok, take_first, lists_empty;
   logic [CW:0]                  total, taken;
   logic                         emit;
   tsm_pkg::rsp_type             pick;

   // List buffers.
   tsm_ram #(.WIDTH(tsm_pkg::VALUE_W), .DEPTH(LIST_DEPTH)) u_first_ram (
      .clock   (clock),
      .wr_en   (wr_first),
      .wr_addr (first_count_ff[AW-1:0]),
      .wr_data (cmd.value),
      .rd_addr (i_ff[AW-1:0]),
      .rd_data (first_rd)
   );

   tsm_ram #(.WIDTH(tsm_pkg::VALUE_W), .DEPTH(LIST_DEPTH)) u_second_ram (
      .clock   (clock),
      .wr_en   (wr_second),
      .wr_addr (second_count_ff[AW-1:0]),
      .wr_data (cmd.value),
      .rd_addr (j_ff[AW-1:0]),
      .rd_data (second_rd)
   );

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tsm_pkg::ST_IDLE: begin
            if (cmd_valid && cmd.kind == tsm_pkg::CMD_MERGE) begin
               state_in = tsm_pkg::ST_FETCH;
            end
         end
         tsm_pkg::ST_FETCH: state_in = tsm_pkg::ST_PICK;
         tsm_pkg::ST_PICK: begin
            if (emit) begin
               state_in = pick.last ? tsm_pkg::ST_IDLE : tsm_pkg::ST_FETCH;
            end
         end
         default: state_in = tsm_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs: command handshake, buffer writes and merge selection.
   always_comb begin
      cmd_ready   = (state_ff == tsm_pkg::ST_IDLE);
      do_cmd      = cmd_valid && cmd_ready;
      first_full  = (first_count_ff == CW'(LIST_DEPTH));
      second_full = (second_count_ff == CW'(LIST_DEPTH));
      wr_first    = do_cmd && cmd.kind == tsm_pkg::CMD_APPEND_FIRST && !first_full;
      wr_second   = do_cmd && cmd.kind == tsm_pkg::CMD_APPEND_SECOND && !second_full;

      a_ok        = (i_ff < first_count_ff);
      b_ok        = (j_ff < second_count_ff);
      take_first  = a_ok && (!b_ok || $signed(first_rd) <= $signed(second_rd));
      total       = {1'b0, first_count_ff} + {1'b0, second_count_ff};
      taken       = {1'b0, i_ff} + {1'b0, j_ff} + 1'b1;
      lists_empty = (total == '0);

      pick.value    = lists_empty ? '0 : (take_first ? first_rd : second_rd);
      pick.last     = lists_empty || (taken == total);
      pick.empty    = lists_empty;
      pick.overflow = dropped_ff;

      emit = (state_ff == tsm_pkg::ST_PICK) && (!out_valid_ff || rsp_pop);
   end

   // Counters, flag, read pointers and the output register.
   always_comb begin
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      dropped_in      = dropped_ff;
      i_in            = i_ff;
      j_in            = j_ff;
      out_valid_in    = out_valid_ff;
      out_in          = out_ff;

      if (do_cmd) begin
         case (cmd.kind)
            tsm_pkg::CMD_APPEND_FIRST: begin
               if (first_full) dropped_in = 1'b1;
               else first_count_in = first_count_ff + 1'b1;
            end
            tsm_pkg::CMD_APPEND_SECOND: begin
               if (second_full) dropped_in = 1'b1;
               else second_count_in = second_count_ff + 1'b1;
            end
            tsm_pkg::CMD_MERGE: begin
               i_in = '0;
               j_in = '0;
            end
            default: begin
               dropped_in = dropped_ff;
            end
         endcase
      end

      if (emit) begin
         if (take_first) begin
            i_in = i_ff + 1'b1;
         end else if (b_ok) begin
            j_in = j_ff + 1'b1;
         end
         // The final result empties both lists and rewinds the pointers.
         if (pick.last) begin
            first_count_in  = '0;
            second_count_in = '0;
            dropped_in      = 1'b0;
            i_in            = '0;
            j_in            = '0;
         end
         out_valid_in = 1'b1;
         out_in       = pick;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= tsm_pkg::ST_IDLE;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         dropped_ff      <= 1'b0;
         i_ff            <= '0;
         j_ff            <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         dropped_ff      <= dropped_in;
         i_ff            <= i_in;
         j_ff            <= j_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

`ifndef SYNTH
   // The merge pointers never run past the filled part of either list.
   assert property (@(posedge clock) disable iff (reset)
      (i_ff <= first_count_ff) && (j_ff <= second_count_ff))
      else $error("merge pointer beyond list fill");

   // The fill counts never exceed the buffer depth.
   assert property (@(posedge clock) disable iff (reset)
      (first_count_ff <= CW'(LIST_DEPTH)) && (second_count_ff <= CW'(LIST_DEPTH)))
      else $error("list fill count beyond depth");

   // Delivering the final result of a merge empties both lists and the flag.
   assert property (@(posedge clock) disable iff (reset)
      (emit && pick.last) |=>
         (first_count_ff == '0 && second_count_ff == '0 && !dropped_ff))
      else $error("lists not cleared after merge");

   // A result is only produced while no new command is being taken.
   assert property (@(posedge clock) disable iff (reset)
      emit |-> !do_cmd)
      else $error("result produced while a command was taken");
`endif

endmodule

### design/two_way_sorted_merge_unit.sv
// ----------------------------------------------------------------------------
// Two-way sorted merge unit
// Buffers two ascending lists of signed values and emits their stable merge.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_push / req_full  req_op, req_value
//   rsp_      out        rsp_empty / rsp_pop  rsp_value_res, rsp_last,
//                                             rsp_empty_res, rsp_overflow
//
// An append is carried out in the back end as it leaves the command queue.
// A merge starts in a fetch state and then alternates fetch and pick per result,
// as each comparison waits on the registered read of the list buffers.
// The two-entry command queue keeps accepting requests while a merge runs.
// A full output register stalls the merge; a full queue raises req_full.
// Reset is synchronous and empties both lists, the flag, the command queue and the output register.
// ----------------------------------------------------------------------------
module two_way_sorted_merge_unit #(
   parameter int LIST_DEPTH = tsm_pkg::LIST_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [tsm_pkg::OP_W-1:0]     req_op,
   input  logic [tsm_pkg::VALUE_W-1:0]  req_value,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [tsm_pkg::VALUE_W-1:0]  rsp_value_res,
   output logic                         rsp_last,
   output logic                         rsp_empty_res,
   output logic                         rsp_overflow
);

   logic              cmd_valid;
   logic              cmd_ready;
   tsm_pkg::cmd_type  cmd;
   logic              rsp_valid;
   tsm_pkg::rsp_type  rsp;

   // Front end: request classification and command queue.
   tsm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_op    (req_op),
      .req_value (req_value),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_ready (cmd_ready)
   );

   // Back end: list buffers and merge sequencer.
   tsm_back #(.LIST_DEPTH(LIST_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_ready (cmd_ready),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .rsp_pop   (rsp_pop)
   );

   // Result channel.
   assign rsp_empty     = !rsp_valid;
   assign rsp_value_res = rsp.value;
   assign rsp_last      = rsp.last;
   assign rsp_empty_res = rsp.empty;
   assign rsp_overflow  = rsp.overflow;

endmodule
